/* src/sedm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sedm_pkg
// shared constants, types and codes for the sequence edit map block
// ----------------------------------------------------------------------------
package sedm_pkg;

  // table sizes
  localparam int MAX_BASES = 1024;
  localparam int MAX_EDITS = 256;
  localparam int MAP_LEN   = MAX_BASES + MAX_EDITS;

  // address and count widths
  localparam int ORIG_AW = $clog2(MAX_BASES);
  localparam int SLOT_AW = $clog2(MAX_EDITS);
  localparam int MAP_AW  = $clog2(MAP_LEN);
  localparam int ENT_W   = MAP_AW;
  localparam int CNT_W   = $clog2(MAP_LEN + 1);

  // field widths
  localparam int KIND_W    = 4;
  localparam int POS_W     = 12;
  localparam int BASE_W    = 8;
  localparam int POINT_W   = 15;
  localparam int TRIM_W    = 11;
  localparam int OUT_CNT_W = 11;

  // stream widths
  localparam int IN_W  = 64;
  localparam int OUT_W = 48;

  // stored word of the original and slot tables: point above base
  localparam int WORD_W = BASE_W + POINT_W;

  // signed widths for index and point arithmetic
  localparam int SP_W  = ((POS_W > CNT_W) ? POS_W : CNT_W) + 2;
  localparam int PT_W  = POINT_W + 2;
  localparam int CUT_W = ((TRIM_W + 1) > CNT_W) ? (TRIM_W + 1) : CNT_W;

  localparam logic signed [SP_W-1:0] SP_ONE = SP_W'(1);
  localparam logic signed [PT_W-1:0] PT_ONE = PT_W'(1);

  // operation codes
  typedef enum logic [KIND_W-1:0] {
    K_LOAD  = 4'd0,
    K_DEL   = 4'd1,
    K_INS   = 4'd2,
    K_RDE   = 4'd3,
    K_RDO   = 4'd4,
    K_FINDE = 4'd5,
    K_FINDO = 4'd6,
    K_CUT   = 4'd7,
    K_CLEAR = 4'd8
  } kind_t;

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_F_MAP,
    S_F_ENT,
    S_RD_ORIG,
    S_RD_DONE,
    S_DEL_RD,
    S_DEL_FREE,
    S_SHIFT_DN,
    S_INS_PV,
    S_INS_NX,
    S_INS_NV,
    S_INS_SR,
    S_SRCH,
    S_S_CMP,
    S_INS_OI,
    S_INS_CK,
    S_SCAN,
    S_SHIFT_UP,
    S_PUT,
    S_RESULT
  } state_t;

  // control into the slot cell row
  typedef struct packed {
    logic               start;
    logic               run;
    logic               set;
    logic               clr;
    logic [SLOT_AW-1:0] addr;
  } slot_ctl_t;

  // status out of the slot cell row
  typedef struct packed {
    logic hit;
    logic fail;
  } slot_sts_t;

endpackage
`default_nettype wire

/* src/sedm_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sedm_ram
// generic simple dual port ram, one write and one registered read
// ----------------------------------------------------------------------------
module sedm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* src/sedm_slot_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sedm_slot_cell
// one replacement slot: its used bit and a scan token passed to the next cell
// ----------------------------------------------------------------------------
module sedm_slot_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  sedm_pkg::slot_ctl_t         ctl,
  input  logic [sedm_pkg::SLOT_AW-1:0] cell_idx,
  input  logic                        pass_in,
  output logic                        pass_out,
  output logic                        hit
);
  import sedm_pkg::*;

  logic used;
  logic tok;

  // used bit, set on allocate and cleared on free
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else if (ctl.set && (ctl.addr == cell_idx)) begin
      used <= 1'b1;
    end else if (ctl.clr && (ctl.addr == cell_idx)) begin
      used <= 1'b0;
    end
  end

  // scan token enters at slot one and walks over used slots
  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= 1'b0;
    end else if (ctl.start) begin
      tok <= (cell_idx == SLOT_AW'(1));
    end else begin
      tok <= ctl.run & pass_in;
    end
  end

  assign pass_out = tok & used;
  assign hit      = tok & ~used;

endmodule
`default_nettype wire

/* src/sedm_slot_row.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sedm_slot_row
// row of slot cells, finds the first free slot one cell per cycle
// ----------------------------------------------------------------------------
module sedm_slot_row (
  input  logic                clk,
  input  logic                rst,
  input  sedm_pkg::slot_ctl_t ctl,
  output sedm_pkg::slot_sts_t sts
);
  import sedm_pkg::*;

  logic [MAX_EDITS-1:0] pass;
  logic [MAX_EDITS-1:0] hit;

  // chain of cells, each fed by its left neighbor
  for (genvar i = 0; i < MAX_EDITS; i++) begin : g_cell
    logic pin;
    if (i == 0) begin : g_first
      assign pin = 1'b0;
    end else begin : g_rest
      assign pin = pass[i-1];
    end
    sedm_slot_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .cell_idx (SLOT_AW'(i)),
      .pass_in  (pin),
      .pass_out (pass[i]),
      .hit      (hit[i])
    );
  end

  // token sitting on a free slot, or falling off the end
  assign sts.hit  = |hit;
  assign sts.fail = pass[MAX_EDITS-1];

endmodule
`default_nettype wire

/* src/sequence_edit_map_top.sv */
`default_nettype none
// load, cutoffs and clear dirty complete in the dispatch state; read edited looks up the map first
// find: a binary search that halves the count each step; edited entries go through the map
// delete: the map tail past the position moves down, one map entry moved per cycle
// insert: binary search, a scan for the first free slot unless a point is reused, tail moves up
// one transaction at a time; the next is taken while a result waits
// reset: control state clears, tables stay undefined until written
// ----------------------------------------------------------------------------
// sequence_edit_map_top
// edited view of a base sequence mapped onto original entries and slots
// ----------------------------------------------------------------------------
module sequence_edit_map_top (
  input  logic                           clk,
  input  logic                           rst,
  // tdata: position[11:0], base_code[19:12], trace_point[34:20],
  // left_trim[45:35], right_trim[56:46], zero fill
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [sedm_pkg::IN_W-1:0]      s_axis_tdata,
  // tuser: kind[3:0]
  input  logic [sedm_pkg::KIND_W-1:0]    s_axis_tuser,
  // tdata: ok[0], base_out[8:1], point_out[23:9], index_out[34:24],
  // edited_count[45:35], dirty_out[46], zero fill
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [sedm_pkg::OUT_W-1:0]     m_axis_tdata,
  // num_points register
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sedm_pkg::POINT_W-1:0]   cfg_data
);
  import sedm_pkg::*;

  state_t state, state_next, fret, fret_next;

  logic [KIND_W-1:0]      kind_r, kind_r_next;
  logic signed [SP_W-1:0] pos_r, pos_r_next;
  logic [BASE_W-1:0]      base_r, base_r_next;
  logic [POINT_W-1:0]     tp_r, tp_r_next;
  logic [TRIM_W-1:0]      lt_r, lt_r_next, rt_r, rt_r_next;

  logic [POINT_W-1:0] num_points;
  logic [CNT_W-1:0]   orig_count, orig_count_next, ed_count, ed_count_next;
  logic [CNT_W-1:0]   left_cut, left_cut_next, right_cut, right_cut_next;
  logic               dirty, dirty_next;

  logic [MAP_AW-1:0]      faddr, faddr_next;
  logic                   is_slot, is_slot_next;
  logic [CNT_W-1:0]       lo, lo_next, hi, hi_next, scnt, scnt_next;
  logic                   sorig, sorig_next, sfound, sfound_next;
  logic [POINT_W:0]       starget, starget_next;
  logic signed [PT_W-1:0] prev_pt, prev_pt_next, next_pt, next_pt_next;
  logic [POINT_W-1:0]     pt_r, pt_r_next;
  logic [ENT_W-1:0]       entry, entry_next;
  logic signed [SP_W-1:0] sh_i, sh_i_next;
  logic [MAP_AW-1:0]      wa, wa_next;
  logic                   pv, pv_next;
  logic [SLOT_AW-1:0]     slot_cnt, slot_cnt_next;

  logic               ok_r, ok_r_next;
  logic [BASE_W-1:0]  base_o, base_o_next;
  logic [POINT_W-1:0] point_o, point_o_next;
  logic [CNT_W-1:0]   index_o, index_o_next;

  logic             m_valid, m_valid_next;
  logic [OUT_W-1:0] m_data, m_data_next;

  // memory ports
  logic               orig_we, slot_we, map_we;
  logic [ORIG_AW-1:0] orig_waddr, orig_raddr;
  logic [SLOT_AW-1:0] slot_waddr, slot_raddr;
  logic [MAP_AW-1:0]  map_waddr, map_raddr;
  logic [WORD_W-1:0]  orig_wdata, orig_rdata, slot_wdata, slot_rdata;
  logic [ENT_W-1:0]   map_wdata, map_rdata;

  slot_ctl_t slot_ctl;
  slot_sts_t slot_sts;

  // shared conditions
  logic                   in_acc, out_free;
  logic signed [SP_W-1:0] n_s, oc_s, lc_s, rc_s, pos_p1;
  logic                   ld_ok, del_ok, ins_ok, rde_ok, rdo_ok, find_ok, cut_ok;
  logic                   ins_head, ins_top, srch_more, tgt_ok, cand, reuse;
  logic                   sh_dn_more, sh_up_more, e_slot, e_free;
  logic [CNT_W:0]         msum;
  logic [CNT_W-1:0]       mid;
  logic signed [PT_W-1:0] tgt, np_m1, pv_s;
  logic signed [PT_W:0]   psum;
  logic [POINT_W-1:0]     mid_pt, fetched_pt;
  logic [BASE_W-1:0]      fetched_base;
  logic [ENT_W-1:0]       esub;
  logic [CUT_W-1:0]       cut_sum;
  logic [WORD_W-1:0]      fetched_word;

  assign in_acc   = s_axis_tvalid & s_axis_tready;
  assign out_free = ~m_valid | m_axis_tready;

  assign n_s    = $signed(SP_W'(ed_count));
  assign oc_s   = $signed(SP_W'(orig_count));
  assign lc_s   = $signed(SP_W'(left_cut));
  assign rc_s   = $signed(SP_W'(right_cut));
  assign pos_p1 = pos_r + SP_ONE;

  // range and cutoff checks
  assign ld_ok  = (orig_count < CNT_W'(MAX_BASES)) && (ed_count < CNT_W'(MAP_LEN));
  assign del_ok = !pos_r[SP_W-1] && (pos_r < n_s) && (pos_r >= lc_s) &&
                  ((pos_r + rc_s) < n_s);
  assign ins_ok = !pos_p1[SP_W-1] && (pos_r < n_s) && (pos_p1 >= lc_s) &&
                  ((pos_r + rc_s) < n_s) && (ed_count < CNT_W'(MAP_LEN));
  assign rde_ok = !pos_r[SP_W-1] && (pos_r < n_s);
  assign rdo_ok = !pos_r[SP_W-1] && (pos_r < oc_s);
  assign find_ok = tp_r < num_points;
  assign cut_sum = CUT_W'(lt_r) + CUT_W'(rt_r);
  assign cut_ok  = cut_sum <= CUT_W'(ed_count);

  assign ins_head = (pos_p1 == '0);
  assign ins_top  = (pos_p1 == n_s);

  // binary search midpoint
  assign msum      = {1'b0, lo} + {1'b0, hi};
  assign mid       = msum[CNT_W:1];
  assign srch_more = lo < hi;

  // fetched entry from the original or slot table
  assign fetched_word = is_slot ? slot_rdata : orig_rdata;
  assign fetched_base = fetched_word[BASE_W-1:0];
  assign fetched_pt   = fetched_word[WORD_W-1:BASE_W];

  // map entry decode
  assign esub   = map_rdata - ENT_W'(MAX_BASES);
  assign e_slot = map_rdata >= ENT_W'(MAX_BASES);
  assign e_free = e_slot && (esub < ENT_W'(MAX_EDITS));

  // insert point arithmetic
  assign np_m1  = $signed(PT_W'(num_points)) - PT_ONE;
  assign tgt    = prev_pt + PT_ONE;
  assign tgt_ok = tgt < $signed(PT_W'(num_points));
  assign pv_s   = $signed(PT_W'(fetched_pt));
  assign cand   = sfound && (prev_pt < pv_s) && (pv_s < next_pt);
  assign reuse  = cand && (fetched_base == base_r);
  assign psum   = {prev_pt[PT_W-1], prev_pt} + {next_pt[PT_W-1], next_pt};
  assign mid_pt = psum[PT_W] ? '0 : psum[POINT_W:1];

  assign sh_dn_more = sh_i < n_s;
  assign sh_up_more = sh_i > pos_r;

  // memories
  sedm_ram #(.WIDTH(WORD_W), .DEPTH(MAX_BASES)) u_orig (
    .clk(clk), .we(orig_we), .waddr(orig_waddr), .wdata(orig_wdata),
    .raddr(orig_raddr), .rdata(orig_rdata)
  );

  sedm_ram #(.WIDTH(WORD_W), .DEPTH(MAX_EDITS)) u_slot (
    .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .raddr(slot_raddr), .rdata(slot_rdata)
  );

  sedm_ram #(.WIDTH(ENT_W), .DEPTH(MAP_LEN)) u_map (
    .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
    .raddr(map_raddr), .rdata(map_rdata)
  );

  sedm_slot_row u_slots (
    .clk(clk), .rst(rst), .ctl(slot_ctl), .sts(slot_sts)
  );

  // read address selection
  always_comb begin
    map_raddr  = '0;
    orig_raddr = '0;
    slot_raddr = esub[SLOT_AW-1:0];
    case (state)
      S_F_MAP:                map_raddr = faddr;
      S_DEL_RD:               map_raddr = pos_r[MAP_AW-1:0];
      S_SHIFT_DN, S_SHIFT_UP: map_raddr = sh_i[MAP_AW-1:0];
      S_F_ENT:                orig_raddr = map_rdata[ORIG_AW-1:0];
      S_RD_ORIG:              orig_raddr = pos_r[ORIG_AW-1:0];
      S_SRCH:                 orig_raddr = mid[ORIG_AW-1:0];
      S_INS_OI:               orig_raddr = hi[ORIG_AW-1:0];
      default:                map_raddr = '0;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (kind_r)
          K_DEL:   state_next = del_ok ? S_DEL_RD : S_RESULT;
          K_INS: begin
            if (!ins_ok) begin
              state_next = S_RESULT;
            end else if (ins_head) begin
              state_next = S_INS_NX;
            end else begin
              state_next = S_F_MAP;
            end
          end
          K_RDE:   state_next = rde_ok ? S_F_MAP : S_RESULT;
          K_RDO:   state_next = rdo_ok ? S_RD_ORIG : S_RESULT;
          K_FINDE, K_FINDO: state_next = find_ok ? S_SRCH : S_RESULT;
          default: state_next = S_RESULT;
        endcase
      end
      S_F_MAP:    state_next = S_F_ENT;
      S_F_ENT:    state_next = fret;
      S_RD_ORIG:  state_next = S_RD_DONE;
      S_RD_DONE:  state_next = S_RESULT;
      S_DEL_RD:   state_next = S_DEL_FREE;
      S_DEL_FREE: state_next = S_SHIFT_DN;
      S_SHIFT_DN: begin
        if (!sh_dn_more && !pv) begin
          state_next = S_RESULT;
        end
      end
      S_INS_PV: state_next = S_INS_NX;
      S_INS_NX: state_next = ins_top ? S_INS_SR : S_F_MAP;
      S_INS_NV: state_next = S_INS_SR;
      S_INS_SR: state_next = tgt_ok ? S_SRCH : S_INS_OI;
      S_SRCH: begin
        if (srch_more) begin
          state_next = sorig ? S_S_CMP : S_F_MAP;
        end else begin
          state_next = (kind_r == K_INS) ? S_INS_OI : S_RESULT;
        end
      end
      S_S_CMP:  state_next = S_SRCH;
      S_INS_OI: state_next = S_INS_CK;
      S_INS_CK: state_next = reuse ? S_SHIFT_UP : S_SCAN;
      S_SCAN: begin
        if (slot_sts.hit) begin
          state_next = S_SHIFT_UP;
        end else if (slot_sts.fail) begin
          state_next = S_RESULT;
        end
      end
      S_SHIFT_UP: begin
        if (!sh_up_more && !pv) begin
          state_next = S_PUT;
        end
      end
      S_PUT: state_next = S_RESULT;
      S_RESULT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath and memory writes
  always_comb begin
    kind_r_next     = kind_r;
    pos_r_next      = pos_r;
    base_r_next     = base_r;
    tp_r_next       = tp_r;
    lt_r_next       = lt_r;
    rt_r_next       = rt_r;
    orig_count_next = orig_count;
    ed_count_next   = ed_count;
    left_cut_next   = left_cut;
    right_cut_next  = right_cut;
    dirty_next      = dirty;
    faddr_next      = faddr;
    fret_next       = fret;
    is_slot_next    = is_slot;
    lo_next         = lo;
    hi_next         = hi;
    scnt_next       = scnt;
    sorig_next      = sorig;
    sfound_next     = sfound;
    starget_next    = starget;
    prev_pt_next    = prev_pt;
    next_pt_next    = next_pt;
    pt_r_next       = pt_r;
    entry_next      = entry;
    sh_i_next       = sh_i;
    wa_next         = wa;
    pv_next         = pv;
    slot_cnt_next   = slot_cnt;
    ok_r_next       = ok_r;
    base_o_next     = base_o;
    point_o_next    = point_o;
    index_o_next    = index_o;
    m_valid_next    = m_valid & ~m_axis_tready;
    m_data_next     = m_data;
    orig_we    = 1'b0;
    orig_waddr = orig_count[ORIG_AW-1:0];
    orig_wdata = {tp_r, base_r};
    slot_we    = 1'b0;
    slot_waddr = slot_cnt;
    slot_wdata = {pt_r, base_r};
    map_we     = 1'b0;
    map_waddr  = wa;
    map_wdata  = map_rdata;
    slot_ctl   = '0;

    case (state)
      // take the transaction fields
      S_IDLE: begin
        if (in_acc) begin
          kind_r_next = s_axis_tuser;
          pos_r_next  = $signed(SP_W'($signed(s_axis_tdata[POS_W-1:0])));
          base_r_next = s_axis_tdata[POS_W +: BASE_W];
          tp_r_next   = s_axis_tdata[POS_W+BASE_W +: POINT_W];
          lt_r_next   = s_axis_tdata[POS_W+BASE_W+POINT_W +: TRIM_W];
          rt_r_next   = s_axis_tdata[POS_W+BASE_W+POINT_W+TRIM_W +: TRIM_W];
        end
      end
      // checks, and the operations that complete in this state
      S_DISPATCH: begin
        ok_r_next    = 1'b0;
        base_o_next  = '0;
        point_o_next = '0;
        index_o_next = '0;
        case (kind_r)
          K_LOAD: begin
            if (ld_ok) begin
              orig_we         = 1'b1;
              map_we          = 1'b1;
              map_waddr       = ed_count[MAP_AW-1:0];
              map_wdata       = orig_count[ENT_W-1:0];
              orig_count_next = orig_count + CNT_W'(1);
              ed_count_next   = ed_count + CNT_W'(1);
              ok_r_next       = 1'b1;
            end
          end
          K_DEL: begin
            if (del_ok) begin
              dirty_next = 1'b1;
            end
          end
          K_INS: begin
            prev_pt_next = -PT_ONE;
            faddr_next   = pos_r[MAP_AW-1:0];
            fret_next    = S_INS_PV;
          end
          K_RDE: begin
            faddr_next = pos_r[MAP_AW-1:0];
            fret_next  = S_RD_DONE;
          end
          K_FINDE, K_FINDO: begin
            lo_next      = '0;
            hi_next      = (kind_r == K_FINDO) ? orig_count : ed_count;
            scnt_next    = (kind_r == K_FINDO) ? orig_count : ed_count;
            sorig_next   = (kind_r == K_FINDO);
            starget_next = {1'b0, tp_r};
          end
          K_CUT: begin
            if (cut_ok) begin
              left_cut_next  = CNT_W'(lt_r);
              right_cut_next = CNT_W'(rt_r);
              ok_r_next      = 1'b1;
            end
          end
          K_CLEAR: begin
            dirty_next = 1'b0;
            ok_r_next  = 1'b1;
          end
          default: ok_r_next = 1'b0;
        endcase
      end
      // map entry read, then its table entry
      S_F_ENT:   is_slot_next = e_slot;
      S_RD_ORIG: is_slot_next = 1'b0;
      S_RD_DONE: begin
        ok_r_next    = 1'b1;
        base_o_next  = fetched_base;
        point_o_next = fetched_pt;
      end
      // free the slot of the deleted entry
      S_DEL_FREE: begin
        slot_ctl.clr  = e_free;
        slot_ctl.addr = esub[SLOT_AW-1:0];
        sh_i_next     = pos_p1;
        pv_next       = 1'b0;
      end
      // move the tail of the map down by one
      S_SHIFT_DN: begin
        map_we  = pv;
        pv_next = sh_dn_more;
        if (sh_dn_more) begin
          sh_i_next = sh_i + SP_ONE;
          wa_next   = sh_i[MAP_AW-1:0] - MAP_AW'(1);
        end
        if (!sh_dn_more && !pv) begin
          ed_count_next = ed_count - CNT_W'(1);
          ok_r_next     = 1'b1;
        end
      end
      // neighbour points
      S_INS_PV: prev_pt_next = pv_s;
      S_INS_NX: begin
        next_pt_next = np_m1;
        faddr_next   = pos_p1[MAP_AW-1:0];
        fret_next    = S_INS_NV;
      end
      S_INS_NV: next_pt_next = pv_s;
      S_INS_SR: begin
        lo_next      = '0;
        hi_next      = orig_count;
        scnt_next    = orig_count;
        sorig_next   = 1'b1;
        starget_next = tgt[POINT_W:0];
        sfound_next  = 1'b0;
      end
      // binary search step
      S_SRCH: begin
        if (srch_more) begin
          is_slot_next = 1'b0;
          faddr_next   = mid[MAP_AW-1:0];
          fret_next    = S_S_CMP;
        end else begin
          sfound_next = (hi != scnt);
          if (kind_r != K_INS) begin
            ok_r_next    = (hi != scnt);
            index_o_next = (hi != scnt) ? hi : '0;
          end
        end
      end
      S_S_CMP: begin
        if ({1'b0, fetched_pt} < starget) begin
          lo_next = mid + CNT_W'(1);
        end else begin
          hi_next = mid;
        end
      end
      S_INS_OI: is_slot_next = 1'b0;
      // pick reuse, original point or midpoint
      S_INS_CK: begin
        pt_r_next      = cand ? fetched_pt : mid_pt;
        entry_next     = hi[ENT_W-1:0];
        slot_ctl.start = !reuse;
        slot_cnt_next  = SLOT_AW'(1);
        sh_i_next      = n_s - SP_ONE;
        pv_next        = 1'b0;
      end
      // walk the slot row for a free slot
      S_SCAN: begin
        slot_ctl.run = 1'b1;
        if (slot_sts.hit) begin
          slot_ctl.set  = 1'b1;
          slot_ctl.addr = slot_cnt;
          slot_we       = 1'b1;
          entry_next    = ENT_W'(MAX_BASES) + ENT_W'(slot_cnt);
        end else if (!slot_sts.fail) begin
          slot_cnt_next = slot_cnt + SLOT_AW'(1);
        end
      end
      // move the tail of the map up by one
      S_SHIFT_UP: begin
        map_we  = pv;
        pv_next = sh_up_more;
        if (sh_up_more) begin
          sh_i_next = sh_i - SP_ONE;
          wa_next   = sh_i[MAP_AW-1:0] + MAP_AW'(1);
        end
      end
      S_PUT: begin
        map_we        = 1'b1;
        map_waddr     = pos_p1[MAP_AW-1:0];
        map_wdata     = entry;
        ed_count_next = ed_count + CNT_W'(1);
        dirty_next    = 1'b1;
        ok_r_next     = 1'b1;
      end
      // hand the result to the output register
      S_RESULT: begin
        if (out_free) begin
          m_valid_next = 1'b1;
          m_data_next  = {1'b0, dirty, OUT_CNT_W'(ed_count), OUT_CNT_W'(index_o),
                          point_o, base_o, ok_r};
        end
      end
      default: ok_r_next = ok_r;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      num_points <= '1;
      orig_count <= '0;
      ed_count   <= '0;
      left_cut   <= '0;
      right_cut  <= '0;
      dirty      <= 1'b0;
      m_valid    <= 1'b0;
    end else begin
      state      <= state_next;
      orig_count <= orig_count_next;
      ed_count   <= ed_count_next;
      left_cut   <= left_cut_next;
      right_cut  <= right_cut_next;
      dirty      <= dirty_next;
      m_valid    <= m_valid_next;
      if (cfg_valid && cfg_ready) begin
        num_points <= cfg_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    kind_r   <= kind_r_next;
    pos_r    <= pos_r_next;
    base_r   <= base_r_next;
    tp_r     <= tp_r_next;
    lt_r     <= lt_r_next;
    rt_r     <= rt_r_next;
    faddr    <= faddr_next;
    fret     <= fret_next;
    is_slot  <= is_slot_next;
    lo       <= lo_next;
    hi       <= hi_next;
    scnt     <= scnt_next;
    sorig    <= sorig_next;
    sfound   <= sfound_next;
    starget  <= starget_next;
    prev_pt  <= prev_pt_next;
    next_pt  <= next_pt_next;
    pt_r     <= pt_r_next;
    entry    <= entry_next;
    sh_i     <= sh_i_next;
    wa       <= wa_next;
    pv       <= pv_next;
    slot_cnt <= slot_cnt_next;
    ok_r     <= ok_r_next;
    base_o   <= base_o_next;
    point_o  <= point_o_next;
    index_o  <= index_o_next;
    m_data   <= m_data_next;
  end

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = m_data;
  assign cfg_ready     = 1'b1;

endmodule
`default_nettype wire

/* src/sedm_check.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sedm_check
// port level checks for the sequence edit map, bound to the top level
// ----------------------------------------------------------------------------
module sedm_check (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [sedm_pkg::OUT_W-1:0]   m_axis_tdata
);
  import sedm_pkg::*;

  // one transaction in flight: no new input right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a transaction is in progress");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // a failed transaction reports no base, point or index
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[34:1] == '0)
    else $error("failed result carries data");

  // reset leaves the block idle and empty
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("block not idle after reset");

endmodule

bind sequence_edit_map_top sedm_check u_sedm_check (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
